// ===== sv/srsw_pkg.sv =====
// shared types and constants for the selective-repeat sender window
package srsw_pkg;

  localparam int ACTION_W   = 2;
  localparam int SEQ_W      = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WSIZE_W    = 6;

  typedef logic [ACTION_W-1:0]   action_t;
  typedef logic [SEQ_W-1:0]      seq_t;
  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam action_t ACT_START = 2'd0;
  localparam action_t ACT_ACK   = 2'd1;
  localparam action_t ACT_TICK  = 2'd2;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam cfg_idx_t CFG_WIN_LIMIT     = 2'd0;
  localparam cfg_idx_t CFG_TOTAL_PACKETS = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [WSIZE_W-1:0] WIN_LIMIT_RST     = 6'd8;
  localparam seq_t               TOTAL_PACKETS_RST = 16'd1;
  localparam seq_t               TIMEOUT_TICKS_RST = 16'd500;

endpackage

// ===== sv/srsw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module srsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/selective_repeat_sender_window.sv =====
// selective-repeat sender window: slot timers in ram, flags and window pointers in flops
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------
//  in       | input     | in_valid / in_stall  | action, ack_seq
//  out      | output    | out_valid / out_stall| kind, packet_index, last
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time: a start runs decode, setup, an admit step per packet and
// flush; an ack at the base adds a slide step per slid packet; a tick runs decode,
// a scan step per in-flight packet, one timer ram slot read per cycle unless held, and flush.
// A stalled output holds the scan or admit step; results are staged one deep
// so the final one can carry last. Synchronous reset clears window state and
// flags; the timer ram needs no clearing since every slot is written on entry.
module selective_repeat_sender_window #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srsw_pkg::action_t          action,
  input  srsw_pkg::seq_t             ack_seq,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       kind,
  output srsw_pkg::seq_t             packet_index,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  srsw_pkg::cfg_idx_t         cfg_index,
  input  srsw_pkg::cfg_data_t        cfg_data
);

  import srsw_pkg::*;

  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OW = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SLIDE  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_ADMIT  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_FLUSH  = 3'd6;

  typedef logic [SW-1:0] slot_t;

  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    r = (s == SW'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
    return r;
  endfunction

  function automatic slot_t slot_wrap(input logic [SW:0] x);
    slot_t r;
    r = (x >= (SW+1)'(WINDOW_MAX)) ? SW'(x - (SW+1)'(WINDOW_MAX)) : SW'(x);
    return r;
  endfunction

  // configuration registers
  logic [WSIZE_W-1:0] win_limit;
  seq_t               total_packets;
  seq_t               timeout_ticks;

  logic [2:0]         state;
  action_t            item_action;
  seq_t               item_seq;

  seq_t               base_index;
  seq_t               end_index;
  slot_t              base_slot;
  logic               finished;
  time_t              tick_count;
  logic [WINDOW_MAX-1:0] flags;

  seq_t               admit_top;
  slot_t              admit_slot;

  seq_t               scan_p;
  slot_t              scan_slot;
  logic               chk_valid;
  seq_t               chk_p;
  slot_t              chk_slot;

  logic               pend_valid;
  logic               pend_kind;
  seq_t               pend_idx;

  // ram control
  logic               ram_we;
  slot_t              ram_waddr;
  slot_t              ram_raddr;
  time_t              ram_rdata;

  logic               out_free;
  logic               push_ok;
  logic               push_en;
  logic               push_kind;
  seq_t               push_idx;
  logic               scan_hold;
  logic               chk_hit;
  time_t              age;

  logic [SEQ_W:0]     eff_win;
  logic [SEQ_W:0]     top_sum;
  logic [SEQ_W:0]     top_min;
  seq_t               top;
  seq_t               seq_off;
  seq_t               end_off;
  slot_t              ack_slot;
  slot_t              end_slot;
  logic               in_win;
  logic               slide_more;

  srsw_ram #(
    .WIDTH(TIME_W),
    .DEPTH(WINDOW_MAX)
  ) u_timer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tick_count),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign push_ok   = !pend_valid || out_free;

  // window top: base + effective window, clipped to the total, never below base
  always_comb begin
    if (win_limit == '0) begin
      eff_win = (SEQ_W+1)'(1);
    end else if ((SEQ_W+1)'(win_limit) > (SEQ_W+1)'(WINDOW_MAX)) begin
      eff_win = (SEQ_W+1)'(WINDOW_MAX);
    end else begin
      eff_win = (SEQ_W+1)'(win_limit);
    end
    top_sum = {1'b0, base_index} + eff_win;
    top_min = (top_sum > {1'b0, total_packets}) ? {1'b0, total_packets} : top_sum;
    top     = (top_min < {1'b0, base_index}) ? base_index : top_min[SEQ_W-1:0];
  end

  // slot of a packet inside the window, relative to the base slot
  assign seq_off  = item_seq - base_index;
  assign end_off  = end_index - base_index;
  assign ack_slot = slot_wrap((SW+1)'(base_slot) + (SW+1)'(seq_off[OW-1:0]));
  assign end_slot = slot_wrap((SW+1)'(base_slot) + (SW+1)'(end_off[OW-1:0]));
  assign in_win   = (item_seq >= base_index) && (item_seq < end_index);
  assign slide_more = (base_index < end_index) && flags[base_slot];

  assign age     = tick_count - ram_rdata;
  assign chk_hit = chk_valid && !flags[chk_slot] && (age > TIME_W'(timeout_ticks));

  always_comb begin
    push_en   = 1'b0;
    push_kind = KIND_SEND;
    push_idx  = '0;
    ram_we    = 1'b0;
    ram_waddr = admit_slot;
    scan_hold = 1'b0;
    unique case (state)
      ST_DECODE: begin
        if (item_action == ACT_START && total_packets == '0) begin
          push_en   = 1'b1;
          push_kind = KIND_DONE;
        end
      end
      ST_SLIDE: begin
        if (!slide_more && base_index >= total_packets) begin
          push_en   = 1'b1;
          push_kind = KIND_DONE;
        end
      end
      ST_ADMIT: begin
        if (push_ok) begin
          push_en  = 1'b1;
          push_idx = end_index;
          ram_we   = 1'b1;
        end
      end
      ST_SCAN: begin
        if (chk_hit) begin
          if (push_ok) begin
            push_en   = 1'b1;
            push_idx  = chk_p;
            ram_we    = 1'b1;
            ram_waddr = chk_slot;
          end else begin
            scan_hold = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    // while held, re-read the slot under check so its data stays in place
    ram_raddr = scan_hold ? chk_slot : scan_slot;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_limit     <= WIN_LIMIT_RST;
      total_packets <= TOTAL_PACKETS_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_LIMIT:     win_limit     <= cfg_data[WSIZE_W-1:0];
        CFG_TOTAL_PACKETS: total_packets <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result staging: pending slot, then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push_en && pend_valid) begin
        out_valid <= 1'b1;
      end else if (state == ST_FLUSH && pend_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        pend_valid <= 1'b1;
      end else if (state == ST_FLUSH && pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      if (pend_valid) begin
        kind         <= pend_kind;
        packet_index <= pend_idx;
        last         <= 1'b0;
      end
      pend_kind <= push_kind;
      pend_idx  <= push_idx;
    end else if (state == ST_FLUSH && pend_valid && out_free) begin
      kind         <= pend_kind;
      packet_index <= pend_idx;
      last         <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base_index <= '0;
      end_index  <= '0;
      base_slot  <= '0;
      finished   <= 1'b0;
      tick_count <= '0;
      flags      <= '0;
      chk_valid  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_action <= action;
            item_seq    <= ack_seq;
            state       <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (item_action)
            ACT_START: begin
              flags      <= '0;
              base_index <= '0;
              end_index  <= '0;
              base_slot  <= '0;
              finished   <= (total_packets == '0);
              state      <= (total_packets == '0) ? ST_FLUSH : ST_SETUP;
            end
            ACT_ACK: begin
              if (!finished && in_win) begin
                flags[ack_slot] <= 1'b1;
                state <= (item_seq == base_index) ? ST_SLIDE : ST_FLUSH;
              end else begin
                state <= ST_FLUSH;
              end
            end
            ACT_TICK: begin
              tick_count <= tick_count + 1'b1;
              if (!finished && base_index < end_index) begin
                scan_p    <= base_index;
                scan_slot <= base_slot;
                chk_valid <= 1'b0;
                state     <= ST_SCAN;
              end else begin
                state <= ST_FLUSH;
              end
            end
            default: state <= ST_FLUSH;
          endcase
        end
        ST_SLIDE: begin
          if (slide_more) begin
            base_index <= base_index + 1'b1;
            base_slot  <= slot_inc(base_slot);
          end else if (base_index >= total_packets) begin
            finished <= 1'b1;
            state    <= ST_FLUSH;
          end else begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (top <= end_index) begin
            // window shrank or nothing new: move the top, send nothing
            end_index <= top;
            state     <= ST_FLUSH;
          end else begin
            admit_top  <= top;
            admit_slot <= end_slot;
            state      <= ST_ADMIT;
          end
        end
        ST_ADMIT: begin
          if (push_ok) begin
            flags[admit_slot] <= 1'b0;
            end_index  <= end_index + 1'b1;
            admit_slot <= slot_inc(admit_slot);
            if (end_index + 1'b1 == admit_top) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_hold) begin
            if (scan_p < end_index) begin
              chk_valid <= 1'b1;
              chk_p     <= scan_p;
              chk_slot  <= scan_slot;
              scan_p    <= scan_p + 1'b1;
              scan_slot <= slot_inc(scan_slot);
            end else begin
              chk_valid <= 1'b0;
              state     <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_base_le_end: assert property (@(posedge clk) disable iff (rst)
    base_index <= end_index)
    else $error("window base beyond window end");

  a_span: assert property (@(posedge clk) disable iff (rst)
    (end_index - base_index) <= SEQ_W'(WINDOW_MAX))
    else $error("window span exceeds slot count");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending result left behind at idle");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> packet_index == '0 && last)
    else $error("completion result with bad fields");

  a_chk_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> state == ST_SCAN)
    else $error("check stage live outside tick scan");
`endif

endmodule

// ===== sim/selective_repeat_sender_window_tb.sv =====
// testbench for the selective-repeat sender window: directed and random items checked against a window predictor
module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  localparam int SLOTS = 32;
  localparam int SETTLE_CYCLES = 80;
  localparam action_t ACT_NONE = 2'd3;

  typedef struct packed {
    logic kind;
    seq_t index;
    logic last;
  } request_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  action_t   action = ACT_START;
  seq_t      ack_seq = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      kind;
  seq_t      packet_index;
  logic      last;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = CFG_WIN_LIMIT;
  cfg_data_t cfg_data = '0;

  // predicted register values and window state
  int unsigned reg_window = WIN_LIMIT_RST;
  int unsigned reg_total = TOTAL_PACKETS_RST;
  int unsigned reg_timeout = TIMEOUT_TICKS_RST;
  int unsigned w_base = 0;
  int unsigned w_end = 0;
  int unsigned tick_now = 0;
  bit          xfer_done = 1'b0;
  bit          slot_acked [SLOTS];
  int unsigned slot_stamp [SLOTS];

  request_t sender_requests[$];
  int batch_n;
  int errors = 0;
  int items_sent = 0;
  int requests_seen = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  // hold-off request from the tests, picked up and counted by the receiver
  int hold_len = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;

  selective_repeat_sender_window #(.WINDOW_MAX(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .ack_seq(ack_seq),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .packet_index(packet_index),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned window_top();
    int unsigned eff;
    int unsigned top;
    eff = reg_window;
    if (eff == 0) eff = 1;
    if (eff > SLOTS) eff = SLOTS;
    top = w_base + eff;
    if (top > reg_total) top = reg_total;
    if (top < w_base) top = w_base;
    return top;
  endfunction

  function automatic void queue_request(logic k, int unsigned idx);
    request_t r;
    r.kind = k;
    r.index = seq_t'(idx);
    r.last = 1'b0;
    sender_requests.push_back(r);
    batch_n++;
  endfunction

  function automatic void admit_to(int unsigned new_end);
    int unsigned p;
    if (new_end > w_end) begin
      for (p = w_end; p < new_end; p++) begin
        slot_acked[p % SLOTS] = 1'b0;
        slot_stamp[p % SLOTS] = tick_now;
        queue_request(KIND_SEND, p);
      end
    end
    // a lower top just shrinks the window, nothing is sent
    w_end = new_end;
  endfunction

  function automatic void advance_window(action_t a, seq_t s);
    int unsigned seq;
    int unsigned p;
    int i;
    request_t r;
    seq = s;
    batch_n = 0;
    case (a)
      ACT_START: begin
        for (i = 0; i < SLOTS; i++) slot_acked[i] = 1'b0;
        w_base = 0;
        w_end = 0;
        xfer_done = 1'b0;
        if (reg_total == 0) begin
          xfer_done = 1'b1;
          queue_request(KIND_DONE, 0);
        end else begin
          admit_to(window_top());
        end
      end
      ACT_ACK: begin
        if (!xfer_done && seq >= w_base && seq < w_end) begin
          slot_acked[seq % SLOTS] = 1'b1;
          if (seq == w_base) begin
            while (w_base < w_end && slot_acked[w_base % SLOTS]) w_base++;
            if (w_base >= reg_total) begin
              xfer_done = 1'b1;
              queue_request(KIND_DONE, 0);
            end else begin
              admit_to(window_top());
            end
          end
        end
      end
      ACT_TICK: begin
        tick_now++;
        if (!xfer_done) begin
          for (p = w_base; p < w_end; p++) begin
            // age is taken modulo 2^32
            if (!slot_acked[p % SLOTS] && (tick_now - slot_stamp[p % SLOTS]) > reg_timeout) begin
              slot_stamp[p % SLOTS] = tick_now;
              queue_request(KIND_SEND, p);
            end
          end
        end
      end
      default: ;
    endcase
    if (batch_n > 0) begin
      r = sender_requests.pop_back();
      r.last = 1'b1;
      sender_requests.push_back(r);
    end
  endfunction

  // receiver side: long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_requests
    request_t want;
    if (!rst && out_valid && !out_stall) begin
      requests_seen++;
      if (sender_requests.size() == 0) begin
        $error("unexpected request: kind %0d packet_index %0d last %0d",
               kind, packet_index, last);
        errors++;
      end else begin
        want = sender_requests.pop_front();
        if (kind !== want.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (packet_index !== want.index) begin
          $error("packet_index mismatch: expected %0d, actual %0d", want.index, packet_index);
          errors++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  task automatic push_item(action_t a, seq_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    ack_seq <= s;
    do @(posedge clk); while (in_stall);
    advance_window(a, s);
    items_sent++;
  endtask

  // drop valid, wait for every predicted request, then let the block settle
  task automatic pause_sender(int extra);
    in_valid <= 1'b0;
    while (sender_requests.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIN_LIMIT:     reg_window = val & 16'h003F;
      CFG_TOTAL_PACKETS: reg_total = val;
      CFG_TIMEOUT_TICKS: reg_timeout = val;
      default: ;
    endcase
  endtask

  task automatic configure(cfg_data_t wsize, cfg_data_t total, cfg_data_t tmo);
    write_reg(CFG_WIN_LIMIT, wsize);
    write_reg(CFG_TOTAL_PACKETS, total);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic: acks inside the window, ticks, restarts; some noise
  task automatic random_items(int want);
    int made;
    int r;
    seq_t s;
    made = 0;
    while (made < want) begin
      r = $urandom_range(99);
      s = seq_t'($urandom_range(65535));
      if (xfer_done || w_end == w_base) begin
        if (r < 85) begin
          push_item(ACT_START, s);
          made++;
        end else if (r < 92) begin
          push_item(ACT_ACK, s);
        end else begin
          push_item(ACT_NONE, s);
        end
      end else if (r < 55) begin
        if (r < 20) s = seq_t'(w_base);
        else s = seq_t'(w_base + $urandom_range(w_end - w_base - 1));
        push_item(ACT_ACK, s);
        made++;
      end else if (r < 85) begin
        push_item(ACT_TICK, s);
        made++;
      end else if (r < 89) begin
        push_item(ACT_START, s);
        made++;
      end else if (r < 95) begin
        push_item(ACT_ACK, s);
      end else begin
        push_item(ACT_NONE, s);
      end
    end
  endtask

  task automatic test_directed_cases();
    snd_idle_pct = 26;
    rcv_stall_pct = 81;
    // reset registers: window 8, one packet
    push_item(ACT_ACK, 16'd0);
    push_item(ACT_TICK, 16'hFFFF);
    push_item(ACT_NONE, 16'hFFFF);
    push_item(ACT_START, 16'd0);
    push_item(ACT_ACK, 16'd1);
    push_item(ACT_ACK, 16'd0);
    push_item(ACT_ACK, 16'd0);
    push_item(ACT_TICK, 16'd0);
    // empty transfer completes on start
    pause_sender(SETTLE_CYCLES);
    configure(16'd0, 16'd0, 16'd1);
    push_item(ACT_START, 16'd0);
    push_item(ACT_ACK, 16'd0);
    // window zero acts as one; upper data bits dropped; age must exceed timeout
    pause_sender(SETTLE_CYCLES);
    configure(16'hFFC0, 16'd3, 16'd1);
    push_item(ACT_START, 16'd0);
    push_item(ACT_TICK, 16'd0);
    push_item(ACT_TICK, 16'd0);
    push_item(ACT_ACK, 16'd0);
    // oversized window acts as the slot count
    pause_sender(SETTLE_CYCLES);
    configure(16'd63, 16'd40, 16'hFFFF);
    push_item(ACT_START, 16'd0);
    push_item(ACT_ACK, 16'd5);
    push_item(ACT_ACK, 16'hFFFF);
    push_item(ACT_ACK, 16'd0);
    // shrink: top moves down, packet 5 comes back with its flag cleared
    pause_sender(SETTLE_CYCLES);
    configure(16'd2, 16'd40, 16'hFFFF);
    push_item(ACT_ACK, 16'd1);
    push_item(ACT_ACK, 16'd2);
    push_item(ACT_ACK, 16'd3);
    // total lowered below the base completes on the next slide
    pause_sender(SETTLE_CYCLES);
    configure(16'd2, 16'd3, 16'hFFFF);
    push_item(ACT_ACK, 16'd4);
  endtask

  task automatic test_random_slow_receiver();
    snd_idle_pct = 26;
    rcv_stall_pct = 81;
    pause_sender(SETTLE_CYCLES);
    configure(16'd5, 16'd45, 16'd4);
    random_items(50);
  endtask

  task automatic test_random_slow_sender();
    snd_idle_pct = 81;
    rcv_stall_pct = 26;
    pause_sender(SETTLE_CYCLES);
    configure(16'd40, 16'd70, 16'd1);
    random_items(50);
  endtask

  task automatic test_output_backlog();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    pause_sender(SETTLE_CYCLES);
    configure(16'd32, 16'd100, 16'd2);
    hold_len = 400;
    hold_gen++;
    push_item(ACT_START, 16'd0);
    random_items(14);
    pause_sender(SETTLE_CYCLES);
    random_items(6);
  endtask

  task automatic test_random_extremes();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    pause_sender(SETTLE_CYCLES);
    configure(16'd1, 16'hFFFF, 16'hFFFF);
    random_items(25);
    pause_sender(SETTLE_CYCLES);
    configure(16'd31, 16'd50, 16'd3);
    random_items(40);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_output_backlog();
    test_random_extremes();
    pause_sender(100);
    $display("covered %0d items and %0d send/complete requests", items_sent, requests_seen);
    $display("windows 1 to 32 incl. out-of-range sizes, totals 0 to 65535, timeouts 1 to 65535");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
